/* hdl/bbe_pkg.sv */
// ----------------------------------------------------------------------------
// Bounding box extents package
// Shared widths, result kinds, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bbe_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int PORT_BITS      = 32;
   localparam int DIFF_BITS      = PORT_BITS + 1;
   localparam int EXT_BITS       = 31;
   localparam int QUO_BITS       = 33;
   localparam int DIV_STEPS      = 33;
   localparam int STEP_BITS      = $clog2(DIV_STEPS);
   localparam int AXES           = 3;
   localparam int POINTS         = 6;
   localparam int PT_BITS        = $clog2(POINTS);
   localparam int KIND_BITS      = 4;

   localparam logic [EXT_BITS-1:0] EXT_SAT = '1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_MIN_CORNER,
      KIND_MAX_CORNER,
      KIND_EXTENTS,
      KIND_MIN_X_POINT,
      KIND_MAX_X_POINT,
      KIND_MIN_Y_POINT,
      KIND_MAX_Y_POINT,
      KIND_MIN_Z_POINT,
      KIND_MAX_Z_POINT,
      KIND_SUMMARY
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_EXTENT,
      ST_RANGE,
      ST_START,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic     take;
      logic     close;
      logic     calc_ext;
      logic     calc_big;
      logic     div_start;
      kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_stat_type;

endpackage

/* hdl/bbe_div.sv */
// ----------------------------------------------------------------------------
// Bounding box reciprocal divider
// Restoring divider, one quotient bit per cycle, giving floor(2^32 / divisor)
// saturated to 31 bits. A zero divisor saturates as well.
// ----------------------------------------------------------------------------
module bbe_div
   import bbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [EXT_BITS-1:0] divisor,
   output logic                busy,
   output logic [EXT_BITS-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [EXT_BITS-1:0]  rem_ff, rem_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [EXT_BITS:0]    trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, (cnt_ff == '0)};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? EXT_BITS'(trial - {1'b0, divisor}) : trial[EXT_BITS-1:0];
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = (|quo_ff[QUO_BITS-1:EXT_BITS]) ? EXT_SAT : quo_ff[EXT_BITS-1:0];

endmodule

/* hdl/bbe_dp.sv */
// ----------------------------------------------------------------------------
// Bounding box datapath
// Running per-axis minimum and maximum, the six extreme points, saturated
// extents, largest extent, reciprocal and the result selection.
// ----------------------------------------------------------------------------
module bbe_dp
   import bbe_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_stat_type                 stat,
   input  logic signed [PORT_BITS-1:0] req_vx,
   input  logic signed [PORT_BITS-1:0] req_vy,
   input  logic signed [PORT_BITS-1:0] req_vz,
   output logic [KIND_BITS-1:0]        rsp_kind,
   output logic signed [PORT_BITS-1:0] rsp_px,
   output logic signed [PORT_BITS-1:0] rsp_py,
   output logic signed [PORT_BITS-1:0] rsp_pz,
   output logic [EXT_BITS-1:0]         rsp_max_extent,
   output logic [EXT_BITS-1:0]         rsp_unit_scale,
   output logic                        rsp_zero_extent,
   output logic                        rsp_final_res
);

   localparam int CW = (COORD_BITS > PORT_BITS) ? PORT_BITS : COORD_BITS;

   logic signed [CW-1:0]  vtx [AXES];
   logic signed [CW-1:0]  min_ff [AXES], min_in [AXES];
   logic signed [CW-1:0]  max_ff [AXES], max_in [AXES];
   logic signed [CW-1:0]  pts_ff [POINTS][AXES], pts_in [POINTS][AXES];
   logic [EXT_BITS-1:0]   ext_ff [AXES], ext_in [AXES];
   logic [DIFF_BITS-1:0]  diff [AXES];
   logic [EXT_BITS-1:0]   big_ff, big_in;
   logic                  first_ff, first_in;
   logic [EXT_BITS-1:0]   scale;
   logic                  div_busy;
   logic [PT_BITS-1:0]    pt_sel;

   assign vtx[0] = req_vx[CW-1:0];
   assign vtx[1] = req_vy[CW-1:0];
   assign vtx[2] = req_vz[CW-1:0];

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      pts_in   = pts_ff;
      first_in = first_ff;
      if (cmd.take) begin
         first_in = cmd.close;
         if (first_ff) begin
            min_in = vtx;
            max_in = vtx;
            for (int k = 0; k < POINTS; k++) begin
               pts_in[k] = vtx;
            end
         end else begin
            for (int a = 0; a < AXES; a++) begin
               if (vtx[a] < min_ff[a]) begin
                  min_in[a]     = vtx[a];
                  pts_in[2*a]   = vtx;
               end
               if (vtx[a] > max_ff[a]) begin
                  max_in[a]     = vtx[a];
                  pts_in[2*a+1] = vtx;
               end
            end
         end
      end
   end

   always_comb begin
      ext_in = ext_ff;
      for (int a = 0; a < AXES; a++) begin
         diff[a] = DIFF_BITS'(max_ff[a]) - DIFF_BITS'(min_ff[a]);
         if (cmd.calc_ext) begin
            ext_in[a] = (|diff[a][DIFF_BITS-1:EXT_BITS]) ? EXT_SAT : diff[a][EXT_BITS-1:0];
         end
      end
   end

   always_comb begin
      big_in = big_ff;
      if (cmd.calc_big) begin
         big_in = ext_ff[0];
         if (big_in < ext_ff[1]) begin
            big_in = ext_ff[1];
         end
         if (big_in < ext_ff[2]) begin
            big_in = ext_ff[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
      pts_ff <= pts_in;
      ext_ff <= ext_in;
      big_ff <= big_in;
   end

   bbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (big_ff),
      .busy     (div_busy),
      .quotient (scale)
   );

   assign stat.div_busy = div_busy;

   always_comb begin
      pt_sel = PT_BITS'(cmd.kind - KIND_MIN_X_POINT);
      case (cmd.kind)
         KIND_MIN_CORNER: begin
            rsp_px = PORT_BITS'(min_ff[0]);
            rsp_py = PORT_BITS'(min_ff[1]);
            rsp_pz = PORT_BITS'(min_ff[2]);
         end
         KIND_MAX_CORNER: begin
            rsp_px = PORT_BITS'(max_ff[0]);
            rsp_py = PORT_BITS'(max_ff[1]);
            rsp_pz = PORT_BITS'(max_ff[2]);
         end
         KIND_EXTENTS: begin
            rsp_px = PORT_BITS'(ext_ff[0]);
            rsp_py = PORT_BITS'(ext_ff[1]);
            rsp_pz = PORT_BITS'(ext_ff[2]);
         end
         KIND_MIN_X_POINT, KIND_MAX_X_POINT, KIND_MIN_Y_POINT,
         KIND_MAX_Y_POINT, KIND_MIN_Z_POINT, KIND_MAX_Z_POINT: begin
            rsp_px = PORT_BITS'(pts_ff[pt_sel][0]);
            rsp_py = PORT_BITS'(pts_ff[pt_sel][1]);
            rsp_pz = PORT_BITS'(pts_ff[pt_sel][2]);
         end
         default: begin
            rsp_px = '0;
            rsp_py = '0;
            rsp_pz = '0;
         end
      endcase
   end

   assign rsp_kind        = cmd.kind;
   assign rsp_max_extent  = big_ff;
   assign rsp_unit_scale  = scale;
   assign rsp_zero_extent = (big_ff == '0);
   assign rsp_final_res   = (cmd.kind == KIND_SUMMARY);

endmodule

/* hdl/bbe_ctrl.sv */
// ----------------------------------------------------------------------------
// Bounding box controller
// Sequences accumulation, extent and reciprocal steps and the ten results.
// ----------------------------------------------------------------------------
module bbe_ctrl
   import bbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   ctrl_state_type state_ff, state_in;
   kind_type       kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         kind_ff  <= KIND_MIN_CORNER;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.take      = 1'b0;
      cmd.close     = 1'b0;
      cmd.calc_ext  = 1'b0;
      cmd.calc_big  = 1'b0;
      cmd.div_start = 1'b0;
      cmd.kind      = kind_ff;
      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            kind_in   = KIND_MIN_CORNER;
            if (req_valid) begin
               cmd.take  = 1'b1;
               cmd.close = req_last;
               if (req_last) begin
                  state_in = ST_EXTENT;
               end
            end
         end
         ST_EXTENT: begin
            cmd.calc_ext = 1'b1;
            state_in     = ST_RANGE;
         end
         ST_RANGE: begin
            cmd.calc_big = 1'b1;
            state_in     = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!stat.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (kind_ff == KIND_SUMMARY) begin
                  state_in = ST_ACCUM;
               end else begin
                  kind_in = kind_type'(kind_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

/* hdl/bounding_box_extents.sv */
// ----------------------------------------------------------------------------
// Bounding box extents
// Axis-aligned bounding box of a Q16.16 vertex stream with extreme points,
// extents and unit-box scale.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while the block accumulates. A vertex
// with req_last set closes the mesh: the block then forms the saturated
// extents, picks the largest, starts the reciprocal and waits for the
// bit-serial reciprocal divider to finish; the ten results then leave at
// one per cycle while rsp_ready is high.
// No vertex is taken from the last vertex until the tenth result is gone.
// Only the low COORD_BITS bits of each coordinate (at most 32) are used.
module bounding_box_extents
   import bbe_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [PORT_BITS-1:0] req_vx,
   input  logic signed [PORT_BITS-1:0] req_vy,
   input  logic signed [PORT_BITS-1:0] req_vz,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [KIND_BITS-1:0]        rsp_kind,
   output logic signed [PORT_BITS-1:0] rsp_px,
   output logic signed [PORT_BITS-1:0] rsp_py,
   output logic signed [PORT_BITS-1:0] rsp_pz,
   output logic [EXT_BITS-1:0]         rsp_max_extent,
   output logic [EXT_BITS-1:0]         rsp_unit_scale,
   output logic                        rsp_zero_extent,
   output logic                        rsp_final_res
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bbe_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_vx          (req_vx),
      .req_vy          (req_vy),
      .req_vz          (req_vz),
      .rsp_kind        (rsp_kind),
      .rsp_px          (rsp_px),
      .rsp_py          (rsp_py),
      .rsp_pz          (rsp_pz),
      .rsp_max_extent  (rsp_max_extent),
      .rsp_unit_scale  (rsp_unit_scale),
      .rsp_zero_extent (rsp_zero_extent),
      .rsp_final_res   (rsp_final_res)
   );

endmodule
